// ===== src/hex_field_frame_parser_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HEX_FIELD_FRAME_PARSER_MACROS_SVH
`define HEX_FIELD_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define HFP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check.
`define HFP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hfp_pkg.sv =====
package hfp_pkg;

    localparam int MAX_HEX_DIGITS_DEF = 8;
    localparam int MIN_FRAME_LEN      = 4;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] SEPARATOR_BYTE = 8'h1F;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_WRONG = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic KIND_CMD   = 1'b0;
    localparam logic KIND_PARAM = 1'b1;

    // One request from the front to the back.
    typedef struct packed {
        logic [7:0] rel;
        logic       absorb;
        logic       emit;
        logic       emit_kind;
        logic       last;
        logic       short_frame;
    } hfp_op_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [2:0]  status;
        logic        done;
    } hfp_result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } hfp_hex_t;

    function automatic hfp_hex_t hex_decode(input logic [7:0] c);
        hfp_hex_t r;
        r.is_hex = 1'b1;
        r.nibble = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.nibble = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            r.nibble = c[3:0] + 4'd9;
        end
        else
        begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/hfp_front.sv =====
module hfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            push,
    output hfp_pkg::hfp_op_t push_op
);
    import hfp_pkg::*;

    localparam logic [2:0] Min = 3'(MIN_FRAME_LEN);

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [2:0] seen_reg, seen_next;
    logic       acc;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        push_op.rel         = held0_reg;
        push_op.absorb      = (seen_reg >= 3'd2)
                              && ((seen_reg < Min) || (held0_reg != SEPARATOR_BYTE));
        push_op.emit        = (seen_reg == Min - 3'd1)
                              || ((seen_reg == Min) && (held0_reg == SEPARATOR_BYTE));
        push_op.emit_kind   = (seen_reg == Min);
        push_op.last        = s_tlast;
        push_op.short_frame = s_tlast && (seen_reg < Min - 3'd1);
        push                = acc && ((seen_reg >= 3'd2) || s_tlast);
    end

    always_comb
    begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        seen_next  = seen_reg;
        if (acc)
        begin
            if (s_tlast)
            begin
                held0_next = 8'd0;
                held1_next = 8'd0;
                seen_next  = 3'd0;
            end
            else
            begin
                held0_next = held1_reg;
                held1_next = s_tdata;
                if (seen_reg < Min)
                begin
                    seen_next = seen_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            seen_reg  <= 3'd0;
        end
        else
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== src/hfp_queue.sv =====
module hfp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hfp_pkg::hfp_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output hfp_pkg::hfp_op_t head_op
);
    import hfp_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    hfp_op_t         entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/hfp_back.sv =====
module hfp_back #(
    parameter int MAX_HEX_DIGITS = hfp_pkg::MAX_HEX_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  hfp_pkg::hfp_op_t    head_op,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output hfp_pkg::hfp_result_t m_result
);
    import hfp_pkg::*;

    localparam int DigW = $clog2(MAX_HEX_DIGITS + 2);

    logic [31:0]     accum_reg, accum_next;
    logic [DigW-1:0] digits_reg, digits_next;
    logic            bad_reg, bad_next;
    logic            valid_reg, valid_next;
    logic            pend_reg, pend_next;
    hfp_result_t     res_reg, res_next;

    hfp_hex_t        hx;
    logic [31:0]     accum_a;
    logic [DigW-1:0] digits_a;
    logic            bad_a;
    logic            end_field;
    logic            need1;
    logic            need2;
    logic            out_free;
    hfp_result_t     field_res;
    hfp_result_t     out_res;
    hfp_result_t     first_res;

    assign m_tvalid = valid_reg;
    assign m_result = res_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        hx       = hex_decode(head_op.rel);
        digits_a = digits_reg;
        accum_a  = accum_reg;
        bad_a    = bad_reg;
        if (head_op.absorb)
        begin
            if (digits_reg <= DigW'(MAX_HEX_DIGITS))
            begin
                digits_a = digits_reg + 1'b1;
            end
            if (hx.is_hex)
            begin
                accum_a = {accum_reg[27:0], hx.nibble};
            end
            else
            begin
                bad_a = 1'b1;
            end
        end

        field_res.kind  = head_op.emit ? head_op.emit_kind : KIND_PARAM;
        field_res.done  = 1'b0;
        if (digits_a == '0)
        begin
            field_res.value  = 32'd0;
            field_res.status = ST_EMPTY;
        end
        else if (bad_a || (digits_a > DigW'(MAX_HEX_DIGITS)))
        begin
            field_res.value  = 32'd0;
            field_res.status = ST_WRONG;
        end
        else
        begin
            field_res.value  = accum_a;
            field_res.status = ST_OK;
        end

        out_res.kind   = KIND_PARAM;
        out_res.value  = 32'd0;
        out_res.status = ST_OUT;
        out_res.done   = 1'b1;

        end_field = head_op.last && !head_op.emit && (digits_a != '0);
        need1     = head_op.emit || head_op.last;
        need2     = head_op.last && !head_op.short_frame && (head_op.emit || (digits_a != '0));

        if (head_op.short_frame)
        begin
            first_res.kind   = KIND_PARAM;
            first_res.value  = 32'd0;
            first_res.status = ST_SHORT;
            first_res.done   = 1'b1;
        end
        else if (head_op.emit || end_field)
        begin
            first_res = field_res;
        end
        else
        begin
            first_res = out_res;
        end

        pop = head_valid && !pend_reg && (!need1 || out_free);
    end

    always_comb
    begin
        valid_next  = valid_reg && !m_tready;
        pend_next   = pend_reg;
        res_next    = res_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        bad_next    = bad_reg;
        // Finish the end-of-frame result before taking the next request.
        if (pend_reg && out_free)
        begin
            valid_next = 1'b1;
            res_next   = out_res;
            pend_next  = 1'b0;
        end
        else if (pop && need1)
        begin
            valid_next = 1'b1;
            res_next   = first_res;
            pend_next  = need2;
        end
        if (pop)
        begin
            if (head_op.emit || head_op.last)
            begin
                accum_next  = 32'd0;
                digits_next = '0;
                bad_next    = 1'b0;
            end
            else
            begin
                accum_next  = accum_a;
                digits_next = digits_a;
                bad_next    = bad_a;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg  <= 32'd0;
            digits_reg <= '0;
            bad_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            bad_reg    <= bad_next;
            valid_reg  <= valid_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ===== src/hex_field_frame_parser.sv =====
// Channel  Dir  Fields
// s_*      in   tdata[7:0] frame_byte, tlast frame_end
// m_*      out  tdata[31:0] item_value, tdata[34:32] item_status, tuser item_kind, tlast frame_done
//
// One byte per cycle in unless the queue is full; each byte reaches the field unit two bytes later.
// A request yields zero, one or two results; the output register sends one a cycle unless stalled,
// so a two-result frame end holds the field unit until its second result is registered.
// A two-entry request queue sits between byte intake and the field unit; when it fills,
// as after a two-result frame end on a steady stream, the input stalls.
// Reset is asynchronous, active low, and returns to the start of a frame.
module hex_field_frame_parser #(
    parameter int MAX_HEX_DIGITS = hfp_pkg::MAX_HEX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] item_value, [34:32] item_status, zero pad
    output logic        m_tuser,   // [0] item_kind
    output logic        m_tlast
);
    import hfp_pkg::*;

    logic        push;
    hfp_op_t     push_op;
    logic        q_full;
    logic        pop;
    logic        head_valid;
    hfp_op_t     head_op;
    hfp_result_t result;

    hfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    hfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    hfp_back #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {5'd0, result.status, result.value};
    assign m_tuser = result.kind;
    assign m_tlast = result.done;

endmodule

// ===== src/hfp_checker.sv =====
`include "hex_field_frame_parser_macros.svh"

module hfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import hfp_pkg::*;

    `HFP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `HFP_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
    `HFP_ASSERT_NOW(a_err_zero, clk, rst_n, m_tvalid && (m_tdata[34:32] != ST_OK), m_tdata[31:0] == 32'd0, "nonzero value on error")
    `HFP_ASSERT_NOW(a_done_end, clk, rst_n, m_tvalid, m_tlast == ((m_tdata[34:32] == ST_OUT) || (m_tdata[34:32] == ST_SHORT)), "frame end mismatch")
    `HFP_ASSERT_NOW(a_cmd_kind, clk, rst_n, m_tvalid && m_tlast, m_tuser == KIND_PARAM, "frame end with command kind")

endmodule

bind hex_field_frame_parser hfp_checker u_hfp_checker (.*);

// ===== bench/hex_field_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module hex_field_frame_parser_tb;
    import hfp_pkg::*;

    localparam int MAX_DIGITS   = MAX_HEX_DIGITS_DEF;
    localparam int RANDOM_BYTES = 1100;
    localparam int DIRECTED_LEN = 29;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_MOSTLY
    } rx_mode_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        eop;
        logic        typed;
        logic [1:0]  count;
        hfp_result_t res_a;
        hfp_result_t res_b;
    } frame_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          errors;
    frame_byte_t directed_tbl [DIRECTED_LEN];
    frame_byte_t frame_bytes_q [$];
    hfp_result_t parsed_fields_q [$];

    // Parser state mirrored from the block
    logic [7:0]  held_old;
    logic [7:0]  held_new;
    logic [2:0]  seen_cnt;
    logic [31:0] field_val;
    logic [3:0]  field_len;
    logic        field_bad;
    hfp_result_t step_res [2];
    int          step_cnt;

    hex_field_frame_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic hfp_result_t make_result(input logic kind, input logic [31:0] value,
                                                input logic [2:0] status, input logic done);
        hfp_result_t r;
        r.kind   = kind;
        r.value  = value;
        r.status = status;
        r.done   = done;
        return r;
    endfunction

    // {is_hex, nibble}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        else
        begin
            return 5'b0_0000;
        end
        return {1'b1, d[3:0]};
    endfunction

    task automatic clear_field();
        field_val = 32'd0;
        field_len = 4'd0;
        field_bad = 1'b0;
    endtask

    task automatic reset_parser();
        held_old = 8'h00;
        held_new = 8'h00;
        seen_cnt = 3'd0;
        clear_field();
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [4:0] d;
        d = nibble_of(c);
        if (field_len <= MAX_DIGITS)
        begin
            field_len = field_len + 4'd1;
        end
        if (d[4])
        begin
            field_val = {field_val[27:0], d[3:0]};
        end
        else
        begin
            field_bad = 1'b1;
        end
    endtask

    function automatic hfp_result_t field_result(input logic kind);
        if (field_len == 4'd0)
        begin
            return make_result(kind, 32'd0, ST_EMPTY, 1'b0);
        end
        else if (field_bad || field_len > MAX_DIGITS)
        begin
            return make_result(kind, 32'd0, ST_WRONG, 1'b0);
        end
        return make_result(kind, field_val, ST_OK, 1'b0);
    endfunction

    task automatic add_step_result(input hfp_result_t r);
        step_res[step_cnt] = r;
        step_cnt++;
    endtask

    // Advance the parser by one byte; results land in step_res
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [2:0] k;
        logic [7:0] rel;
        k = seen_cnt;
        rel = held_old;
        step_cnt = 0;
        if (k >= 3'd2)
        begin
            if (k < MIN_FRAME_LEN)
            begin
                take_char(rel);
                if (k == 3'd3)
                begin
                    add_step_result(field_result(KIND_CMD));
                    clear_field();
                end
            end
            else if (rel == SEPARATOR_BYTE)
            begin
                add_step_result(field_result(KIND_PARAM));
                clear_field();
            end
            else
            begin
                take_char(rel);
            end
        end
        held_old = held_new;
        held_new = b;
        if (seen_cnt < MIN_FRAME_LEN)
        begin
            seen_cnt = seen_cnt + 3'd1;
        end
        if (eop)
        begin
            if (int'(k) + 1 < MIN_FRAME_LEN)
            begin
                step_cnt = 0;
                add_step_result(make_result(KIND_PARAM, 32'd0, ST_SHORT, 1'b1));
            end
            else
            begin
                if (field_len != 4'd0)
                begin
                    add_step_result(field_result(KIND_PARAM));
                end
                add_step_result(make_result(KIND_PARAM, 32'd0, ST_OUT, 1'b1));
            end
            reset_parser();
        end
    endtask

    function automatic frame_byte_t row(input logic [7:0] b, input logic eop);
        frame_byte_t r;
        r = '0;
        r.data = b;
        r.eop  = eop;
        return r;
    endfunction

    function automatic frame_byte_t typed_row(input logic [7:0] b, input logic eop,
                                              input logic [1:0] count,
                                              input hfp_result_t ra, input hfp_result_t rb);
        frame_byte_t r;
        r = row(b, eop);
        r.typed = 1'b1;
        r.count = count;
        r.res_a = ra;
        r.res_b = rb;
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eop);
        frame_bytes_q.push_back(row(b, eop));
    endtask

    function automatic logic [7:0] hex_char();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10)
        begin
            return 8'(8'h30 + idx);
        end
        else if (idx < 16)
        begin
            return 8'(8'h41 + idx - 10);
        end
        return 8'(8'h61 + idx - 16);
    endfunction

    function automatic logic [7:0] maybe_hex();
        if ($urandom_range(0, 29) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return hex_char();
    endfunction

    function automatic logic [7:0] check_char();
        if ($urandom_range(0, 5) == 0)
        begin
            return SEPARATOR_BYTE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic append_frame();
        int shape;
        int len;
        int n_params;
        int n_chars;
        int i;
        int p;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            // short frame
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++)
            begin
                push_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
        end
        else if (shape == 1)
        begin
            // raw noise, separators sprinkled in
            len = $urandom_range(4, 14);
            for (i = 0; i < len; i++)
            begin
                push_byte(($urandom_range(0, 3) == 0) ? SEPARATOR_BYTE
                                                      : 8'($urandom_range(0, 255)),
                          i == len - 1);
            end
        end
        else
        begin
            push_byte(maybe_hex(), 1'b0);
            push_byte(maybe_hex(), 1'b0);
            n_params = $urandom_range(0, 4);
            for (p = 0; p < n_params; p++)
            begin
                if (p != 0)
                begin
                    push_byte(SEPARATOR_BYTE, 1'b0);
                end
                case ($urandom_range(0, 9))
                    0:       n_chars = 0;
                    1:       n_chars = MAX_DIGITS + 1;
                    2:       n_chars = MAX_DIGITS;
                    3:       n_chars = $urandom_range(MAX_DIGITS + 2, MAX_DIGITS + 4);
                    default: n_chars = $urandom_range(1, MAX_DIGITS - 1);
                endcase
                for (i = 0; i < n_chars; i++)
                begin
                    push_byte(maybe_hex(), 1'b0);
                end
            end
            if (n_params != 0 && $urandom_range(0, 4) == 0)
            begin
                push_byte(SEPARATOR_BYTE, 1'b0);
            end
            push_byte(check_char(), 1'b0);
            push_byte(check_char(), 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Sender: bursts with random gaps, hold each request until accepted
    initial
    begin
        int          burst_left;
        int          gap;
        int          i;
        frame_byte_t cur;
        hfp_result_t short_res;
        hfp_result_t out_res;
        hfp_result_t bad_cmd;
        errors = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        reset_parser();

        short_res = make_result(KIND_PARAM, 32'd0, ST_SHORT, 1'b1);
        out_res   = make_result(KIND_PARAM, 32'd0, ST_OUT, 1'b1);
        bad_cmd   = make_result(KIND_CMD, 32'd0, ST_WRONG, 1'b0);
        directed_tbl = '{
            // two-byte frame, byte extremes
            typed_row(8'h00, 1'b0, 2'd0, '0, '0),
            typed_row(8'hFF, 1'b1, 2'd1, short_res, '0),
            // minimum length frame, non-hex command digit
            typed_row(8'h67, 1'b0, 2'd0, '0, '0),
            typed_row(8'h30, 1'b0, 2'd0, '0, '0),
            typed_row(8'h63, 1'b0, 2'd0, '0, '0),
            typed_row(8'h63, 1'b1, 2'd2, bad_cmd, out_res),
            // full-width field, empty field, overlong last field, separator checksum
            row(8'h46, 1'b0), row(8'h66, 1'b0),
            row(8'h46, 1'b0), row(8'h46, 1'b0), row(8'h46, 1'b0), row(8'h46, 1'b0),
            row(8'h46, 1'b0), row(8'h46, 1'b0), row(8'h46, 1'b0), row(8'h46, 1'b0),
            row(SEPARATOR_BYTE, 1'b0), row(SEPARATOR_BYTE, 1'b0),
            row(8'h31, 1'b0), row(8'h32, 1'b0), row(8'h33, 1'b0), row(8'h34, 1'b0),
            row(8'h35, 1'b0), row(8'h36, 1'b0), row(8'h37, 1'b0), row(8'h38, 1'b0),
            row(8'h39, 1'b0),
            row(SEPARATOR_BYTE, 1'b0), row(SEPARATOR_BYTE, 1'b1)
        };
        foreach (directed_tbl[j])
        begin
            frame_bytes_q.push_back(directed_tbl[j]);
        end
        while (frame_bytes_q.size() < DIRECTED_LEN + RANDOM_BYTES)
        begin
            append_frame();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        while (frame_bytes_q.size() != 0)
        begin
            cur = frame_bytes_q.pop_front();
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= cur.data;
            s_tlast  <= cur.eop;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            parse_byte(cur.data, cur.eop);
            if (cur.typed)
            begin
                if (cur.count > 2'd0)
                begin
                    parsed_fields_q.push_back(cur.res_a);
                end
                if (cur.count > 2'd1)
                begin
                    parsed_fields_q.push_back(cur.res_b);
                end
            end
            else
            begin
                for (i = 0; i < step_cnt; i++)
                begin
                    parsed_fields_q.push_back(step_res[i]);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b0;

        while (parsed_fields_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("hex_field_frame_parser test passed");
        end
        else
        begin
            $display("hex_field_frame_parser test failed");
        end
        $finish;
    end

    // Receiver: changing stall patterns plus one long hold-off
    initial
    begin
        int       cyc;
        int       hold_left;
        int       span_left;
        rx_mode_t mode;
        m_tready <= 1'b0;
        cyc = 0;
        hold_left = 0;
        span_left = 0;
        mode = RX_OPEN;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_START)
            begin
                hold_left = HOLD_CYCLES;
            end
            if (span_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span_left = $urandom_range(10, 60);
            end
            span_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_THIRD: m_tready <= (cyc % 3 == 0);
                    default:  m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        hfp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parsed_fields_q.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = parsed_fields_q.pop_front();
                if (m_tuser !== want.kind)
                begin
                    report_mismatch("item_kind", 32'(m_tuser), 32'(want.kind));
                end
                if (m_tdata[31:0] !== want.value)
                begin
                    report_mismatch("item_value", m_tdata[31:0], want.value);
                end
                if (m_tdata[34:32] !== want.status)
                begin
                    report_mismatch("item_status", 32'(m_tdata[34:32]), 32'(want.status));
                end
                if (m_tlast !== want.done)
                begin
                    report_mismatch("frame_done", 32'(m_tlast), 32'(want.done));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("hex_field_frame_parser test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/hfp_pkg.sv
src/hfp_front.sv
src/hfp_queue.sv
src/hfp_back.sv
src/hex_field_frame_parser.sv
src/hfp_checker.sv
bench/hex_field_frame_parser_tb.sv
